// File: rtl/bts_pkg.sv
package bts_pkg;

  typedef enum logic [2:0] {
    M_START   = 3'd0,
    M_NUM     = 3'd1,
    M_IDENT   = 3'd2,
    M_LT      = 3'd3,
    M_EQ      = 3'd4,
    M_GT      = 3'd5,
    M_COMMENT = 3'd6
  } scan_mode_t;

  localparam logic [2:0] K_NUM = 3'd0;
  localparam logic [2:0] K_ID  = 3'd1;
  localparam logic [2:0] K_KEY = 3'd2;
  localparam logic [2:0] K_OP  = 3'd3;
  localparam logic [2:0] K_LP  = 3'd4;
  localparam logic [2:0] K_RP  = 3'd5;
  localparam logic [2:0] K_END = 3'd6;

  // Up to two kinds per character, in emission order.
  typedef struct packed {
    logic [1:0] count;
    logic [2:0] kind0;
    logic [2:0] kind1;
  } tok_pair_t;

  localparam int QUEUE_DEPTH = 4;

endpackage

// File: rtl/bts_if.sv
interface bts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;
  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink (input valid, input ch, input end_of_input, output ready);
endinterface

interface bts_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  modport source (output valid, output kind, input ready);
  modport sink (input valid, input kind, output ready);
endinterface

// File: rtl/bts_front.sv
module bts_front #(
  parameter int POSITION_BITS = 32,
  parameter int MAX_IDENT_LEN = 255
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           ch,
  input  logic                 end_of_input,
  output bts_pkg::tok_pair_t   toks
);
  import bts_pkg::*;

  localparam int LEN_BITS = $clog2(MAX_IDENT_LEN + 1);

  scan_mode_t               mode, mode_next;
  logic [30:0]              accum, accum_next;
  logic                     ovf, ovf_next;
  logic [LEN_BITS-1:0]      len, len_next;
  logic [POSITION_BITS-1:0] start, start_next;
  logic [POSITION_BITS-1:0] pos;
  logic [39:0]              win, win_next;

  logic is_dig, is_alp, is_ws, id_ch, is_kw, fresh;
  logic [34:0] prod;
  logic [35:0] sum;

  function automatic tok_pair_t add_tok(tok_pair_t t, logic [2:0] k);
    tok_pair_t r;
    r = t;
    if (t.count == 2'd0) r.kind0 = k;
    else r.kind1 = k;
    r.count = t.count + 2'd1;
    return r;
  endfunction

  always_comb begin
    is_dig = ch >= 8'h30 && ch <= 8'h39;
    is_alp = (ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h41 && ch <= 8'h5a);
    is_ws  = ch == 8'h20 || ch == 8'h0a || ch == 8'h09;
    id_ch  = is_alp || is_dig || ch == 8'h5f;
    is_kw  = (len == LEN_BITS'(5) && (win == 40'h696e707574 || win == 40'h7072696e74)) ||
             (len == LEN_BITS'(3) && (win == 40'h6c6574 || win == 40'h656e64)) ||
             (len == LEN_BITS'(4) && win == 40'h676f746f) ||
             (len == LEN_BITS'(2) && win == 40'h6966);
    prod = {accum, 3'b000} + {3'b000, accum, 1'b0};
    sum  = {1'b0, prod} + {32'd0, ch[3:0]};
  end

  always_comb begin
    mode_next  = mode;
    accum_next = accum;
    ovf_next   = ovf;
    len_next   = len;
    start_next = start;
    win_next   = win;
    toks       = '0;
    fresh      = 1'b0;
    if (end_of_input) begin
      unique case (mode)
        M_NUM:              toks = add_tok(toks, K_NUM);
        M_IDENT:            toks = add_tok(toks, is_kw ? K_KEY : K_ID);
        M_LT, M_EQ, M_GT:   toks = add_tok(toks, K_OP);
        default: ;
      endcase
      toks = add_tok(toks, K_END);
      mode_next = M_START;
      accum_next = '0; ovf_next = 1'b0; len_next = '0; start_next = '0; win_next = '0;
    end else begin
      unique case (mode)
        M_NUM: begin
          if (is_dig) begin
            if (sum > 36'h7fffffff) begin
              accum_next = 31'h7fffffff; ovf_next = 1'b1;
            end else accum_next = sum[30:0];
          end else begin
            toks = add_tok(toks, K_NUM); fresh = 1'b1;
          end
        end
        M_IDENT: begin
          if (id_ch) begin
            if (len < LEN_BITS'(5)) win_next = {win[31:0], ch};
            if (len < LEN_BITS'(MAX_IDENT_LEN)) len_next = len + LEN_BITS'(1);
            if (len_next == LEN_BITS'(3) && win_next == 40'h72656d) mode_next = M_COMMENT;
          end else begin
            toks = add_tok(toks, is_kw ? K_KEY : K_ID); fresh = 1'b1;
          end
        end
        M_LT: begin
          toks = add_tok(toks, K_OP); mode_next = M_START;
          fresh = !(ch == 8'h3e || ch == 8'h3d);
        end
        M_EQ, M_GT: begin
          toks = add_tok(toks, K_OP); mode_next = M_START;
          fresh = ch != 8'h3d;
        end
        M_COMMENT: if (ch == 8'h0a) mode_next = M_START;
        default: fresh = 1'b1;
      endcase
      if (fresh) begin
        mode_next = M_START;
        if (is_ws) begin
        end else if (is_dig) begin
          mode_next = M_NUM; accum_next = {27'd0, ch[3:0]}; ovf_next = 1'b0;
        end else if (is_alp || ch == 8'h5f) begin
          mode_next = M_IDENT; start_next = pos; len_next = LEN_BITS'(1);
          win_next = {32'd0, ch};
        end else if (ch == 8'h2b || ch == 8'h2d || ch == 8'h2a || ch == 8'h2f) begin
          toks = add_tok(toks, K_OP);
        end else if (ch == 8'h3c) mode_next = M_LT;
        else if (ch == 8'h3d) mode_next = M_EQ;
        else if (ch == 8'h3e) mode_next = M_GT;
        else if (ch == 8'h28) toks = add_tok(toks, K_LP);
        else if (ch == 8'h29) toks = add_tok(toks, K_RP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_START; accum <= '0; ovf <= 1'b0; len <= '0;
      start <= '0; pos <= '0; win <= '0;
    end else if (step) begin
      mode <= mode_next; accum <= accum_next; ovf <= ovf_next; len <= len_next;
      start <= start_next; win <= win_next;
      pos <= end_of_input ? '0 : pos + POSITION_BITS'(1);
    end
  end
endmodule

// File: rtl/bts_back.sv
module bts_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bts_pkg::tok_pair_t toks,
  output logic               has_room,
  output logic               busy,
  bts_out_if.source          out_ch
);
  import bts_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [2:0]  mem [QUEUE_DEPTH];
  logic [AW-1:0] wr, rd;
  logic [AW:0] fill, fill_next;
  logic pop;

  assign pop       = out_ch.valid && out_ch.ready;
  assign out_ch.valid = fill != '0;
  assign out_ch.kind  = mem[rd];
  assign has_room  = fill <= (AW+1)'(QUEUE_DEPTH - 2);
  assign busy      = fill != '0;

  always_comb begin
    fill_next = fill - (AW+1)'(pop);
    if (push) fill_next = fill_next + (AW+1)'(toks.count);
  end

  always_ff @(posedge clk) begin
    if (push && toks.count != 2'd0) mem[wr] <= toks.kind0;
    if (push && toks.count == 2'd2) mem[wr + AW'(1)] <= toks.kind1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0; rd <= '0; fill <= '0;
    end else begin
      fill <= fill_next;
      if (pop) rd <= rd + AW'(1);
      if (push) wr <= wr + AW'(toks.count);
    end
  end
endmodule

// File: rtl/basic_token_scanner_top.sv
// Token scanner for a small BASIC-like language.
// The in channel carries one source character per word, or an end-of-input
// mark; the out channel carries one token kind per word.
// A character is classified in the cycle it is accepted, and its tokens (none,
// one or two) are written into a four-entry queue, whose registered head drives
// the out channel, behind any tokens still waiting there.
// One character is taken every cycle while the queue has room for two more
// words; the queue is drained at one token per cycle while out.ready is high,
// which sets the sustained rate when the stream yields more than one token per
// character. When the receiver stalls, the queue fills and in.ready falls until it drains.
// Reset clears the scanner state, the position counter and the queue.
// End of input flushes any pending token, emits the end kind and returns the
// scanner to its start state for a new stream.
module basic_token_scanner_top #(
  parameter int POSITION_BITS = 32,
  parameter int MAX_IDENT_LEN = 255
) (
  input logic     clk,
  input logic     rst,
  bts_in_if.sink  in_ch,
  bts_out_if.source out_ch
);
  import bts_pkg::*;

  tok_pair_t toks;
  logic      room, busy, step;

  // The front only advances on an accepted word.
  assign step        = in_ch.valid && in_ch.ready;
  assign in_ch.ready = room;

  bts_front #(.POSITION_BITS(POSITION_BITS), .MAX_IDENT_LEN(MAX_IDENT_LEN)) u_front (
    .clk, .rst, .step, .ch(in_ch.ch), .end_of_input(in_ch.end_of_input), .toks
  );

  bts_back u_back (
    .clk, .rst, .push(step), .toks, .has_room(room), .busy, .out_ch
  );

  // An end-of-input word always yields at least one token.
  a_eoi_emits: assert property (@(posedge clk) disable iff (rst)
    step && in_ch.end_of_input |-> toks.count != 2'd0)
    else $error("end of input produced no token");

  // Nothing is offered downstream with an empty queue.
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> busy)
    else $error("output valid without queued token");

  // Accepting a word always leaves the queue room for its tokens.
  a_room: assert property (@(posedge clk) disable iff (rst)
    step |-> room)
    else $error("word accepted without queue room");
endmodule
